// File: design/qvr_pkg.sv
package qvr_pkg;

  // Width of one vector component on the ports.
  localparam int VecWidth = 16;

  // Quaternion components are Q2.14.
  localparam int QuatW = 16;
  // Exact quaternion product, Q4.28.
  localparam int ProdW = 2 * QuatW;
  // Raw matrix entry in units of 2^-28, with headroom for 2*(a +/- b).
  localparam int RawW = ProdW + 3;
  // Matrix entry after rounding to 16 fractional bits.
  localparam int EntW = RawW - 13;
  // Entry times component, and the sum of three of them.
  localparam int LprW = EntW + VecWidth;
  localparam int AccW = LprW + 2;

  localparam logic signed [RawW-1:0] OneRaw = RawW'(2 ** 28);
  localparam logic signed [RawW-1:0] RndEnt = RawW'(2 ** 11);
  localparam logic signed [AccW-1:0] RndOut = AccW'(2 ** 15);

  localparam logic signed [AccW-1:0] VecMax =
    {{(AccW - VecWidth + 1){1'b0}}, {(VecWidth - 1){1'b1}}};
  localparam logic signed [AccW-1:0] VecMin = ~VecMax;

  typedef logic signed [QuatW-1:0]    quat_comp_t;
  typedef logic signed [VecWidth-1:0] vec_t;
  typedef vec_t [2:0]                 vec3_t;
  typedef logic signed [ProdW-1:0]    prod_t;
  typedef logic signed [RawW-1:0]     raw_t;
  typedef logic signed [EntW-1:0]     entry_t;
  typedef entry_t [2:0]               row_t;
  typedef row_t [2:0]                 mat_t;
  typedef logic signed [LprW-1:0]     lprod_t;
  typedef logic signed [AccW-1:0]     acc_t;

  typedef struct packed {
    quat_comp_t w;
    quat_comp_t x;
    quat_comp_t y;
    quat_comp_t z;
  } quat_t;

  // Load enables of the four internal pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } qvr_adv_t;

  function automatic raw_t prod_ext(prod_t p);
    return {{(RawW - ProdW){p[ProdW-1]}}, p};
  endfunction

  // Round half up to 16 fractional bits: add 2^11, shift right by 12.
  function automatic entry_t entry_round(raw_t raw);
    raw_t sum;
    raw_t shr;
    sum = raw + RndEnt;
    shr = sum >>> 12;
    return shr[EntW-1:0];
  endfunction

  function automatic acc_t lprod_ext(lprod_t p);
    return {{(AccW - LprW){p[LprW-1]}}, p};
  endfunction

endpackage

// File: design/qvr_if.sv
interface qvr_in_if import qvr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       mode;
  quat_comp_t quat_w;
  quat_comp_t quat_x;
  quat_comp_t quat_y;
  quat_comp_t quat_z;
  vec_t       vec_in_x;
  vec_t       vec_in_y;
  vec_t       vec_in_z;

  modport source(
    output valid, mode, quat_w, quat_x, quat_y, quat_z, vec_in_x, vec_in_y, vec_in_z,
    input  ready
  );
  modport sink(
    input  valid, mode, quat_w, quat_x, quat_y, quat_z, vec_in_x, vec_in_y, vec_in_z,
    output ready
  );
endinterface

interface qvr_out_if import qvr_pkg::*; ();
  logic valid;
  logic ready;
  vec_t vec_out_x;
  vec_t vec_out_y;
  vec_t vec_out_z;
  logic saturated;

  modport source(
    output valid, vec_out_x, vec_out_y, vec_out_z, saturated,
    input  ready
  );
  modport sink(
    input  valid, vec_out_x, vec_out_y, vec_out_z, saturated,
    output ready
  );
endinterface

// File: design/quaternion_vector_rotator_core.sv
// Channel  Direction  Beat contents
// in_i     sink       mode, quat_w/x/y/z (Q2.14), vec_in_x/y/z
// out_o    source     vec_out_x/y/z (rounded, clipped), saturated
//
// The five pipeline registers are products, matrix, lane products, lane
// results and merge; one beat is taken every cycle unless the output stalls.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits.
// A stalled output holds its register; each stage refills as soon as the one
// after it moves or is empty, so bubbles close up under backpressure.
module quaternion_vector_rotator_core import qvr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  qvr_in_if.sink     in_i,
  qvr_out_if.source  out_o
);

  // Stage valid bits: index 0 is the product stage, index 4 the output register.
  logic [4:0] vld_q;
  logic [4:0] vld_d;
  logic [4:0] rdy;
  logic [4:0] adv;
  logic [4:0] prev_vld;

  always_comb begin
    prev_vld = {vld_q[3:0], in_i.valid};
    rdy[4]   = !vld_q[4] || out_o.ready;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    adv   = rdy & prev_vld;
    vld_d = (rdy & prev_vld) | (~rdy & vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready = rdy[0];

  qvr_adv_t adv_s;
  assign adv_s = '{s1: adv[0], s2: adv[1], s3: adv[2], s4: adv[3]};

  // Quaternion products and the rotation matrix, shared by all lanes.
  quat_t quat;
  vec3_t vec_in;
  mat_t  mat;
  vec3_t vec_m;

  assign quat   = '{w: in_i.quat_w, x: in_i.quat_x, y: in_i.quat_y, z: in_i.quat_z};
  assign vec_in = {in_i.vec_in_z, in_i.vec_in_y, in_i.vec_in_x};

  qvr_matrix u_matrix (
    .clk_i  (clk_i),
    .adv_i  (adv_s),
    .mode_i (in_i.mode),
    .quat_i (quat),
    .vec_i  (vec_in),
    .mat_o  (mat),
    .vec_o  (vec_m)
  );

  // One lane per matrix row: each forms one output component.
  vec3_t      lane_res;
  logic [2:0] lane_sat;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    qvr_lane u_lane (
      .clk_i (clk_i),
      .adv_i (adv_s),
      .row_i (mat[g]),
      .vec_i (vec_m),
      .res_o (lane_res[g]),
      .sat_o (lane_sat[g])
    );
  end

  // Merge stage: gather the lane results and combine their clip flags.
  vec3_t res_q;
  logic  sat_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      res_q <= lane_res;
      sat_q <= |lane_sat;
    end
  end

  assign out_o.valid     = vld_q[4];
  assign out_o.vec_out_x = res_q[0];
  assign out_o.vec_out_y = res_q[1];
  assign out_o.vec_out_z = res_q[2];
  assign out_o.saturated = sat_q;

endmodule

// File: design/qvr_matrix.sv
module qvr_matrix import qvr_pkg::*; (
  input  logic     clk_i,
  input  qvr_adv_t adv_i,
  input  logic     mode_i,
  input  quat_t    quat_i,
  input  vec3_t    vec_i,
  output mat_t     mat_o,
  output vec3_t    vec_o
);

  // Stage 1: the ten distinct quaternion products, exact in Q4.28.
  prod_t p_ww_q, p_xx_q, p_yy_q, p_zz_q;
  prod_t p_wx_q, p_wy_q, p_wz_q, p_xy_q, p_xz_q, p_yz_q;
  logic  mode_q;
  vec3_t vec1_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      p_ww_q <= prod_t'(quat_i.w) * prod_t'(quat_i.w);
      p_xx_q <= prod_t'(quat_i.x) * prod_t'(quat_i.x);
      p_yy_q <= prod_t'(quat_i.y) * prod_t'(quat_i.y);
      p_zz_q <= prod_t'(quat_i.z) * prod_t'(quat_i.z);
      p_wx_q <= prod_t'(quat_i.w) * prod_t'(quat_i.x);
      p_wy_q <= prod_t'(quat_i.w) * prod_t'(quat_i.y);
      p_wz_q <= prod_t'(quat_i.w) * prod_t'(quat_i.z);
      p_xy_q <= prod_t'(quat_i.x) * prod_t'(quat_i.y);
      p_xz_q <= prod_t'(quat_i.x) * prod_t'(quat_i.z);
      p_yz_q <= prod_t'(quat_i.y) * prod_t'(quat_i.z);
      mode_q <= mode_i;
      vec1_q <= vec_i;
    end
  end

  // Stage 2: rounded matrix entries, transposed when mode is set.
  entry_t e [9];
  mat_t   mat_d;
  mat_t   mat_q;
  vec3_t  vec2_q;

  always_comb begin
    e[0] = entry_round(((prod_ext(p_ww_q) + prod_ext(p_xx_q)) <<< 1) - OneRaw);
    e[1] = entry_round((prod_ext(p_xy_q) - prod_ext(p_wz_q)) <<< 1);
    e[2] = entry_round((prod_ext(p_xz_q) + prod_ext(p_wy_q)) <<< 1);
    e[3] = entry_round((prod_ext(p_xy_q) + prod_ext(p_wz_q)) <<< 1);
    e[4] = entry_round(((prod_ext(p_ww_q) + prod_ext(p_yy_q)) <<< 1) - OneRaw);
    e[5] = entry_round((prod_ext(p_yz_q) - prod_ext(p_wx_q)) <<< 1);
    e[6] = entry_round((prod_ext(p_xz_q) - prod_ext(p_wy_q)) <<< 1);
    e[7] = entry_round((prod_ext(p_yz_q) + prod_ext(p_wx_q)) <<< 1);
    e[8] = entry_round(((prod_ext(p_ww_q) + prod_ext(p_zz_q)) <<< 1) - OneRaw);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat_d[i][j] = mode_q ? e[3 * j + i] : e[3 * i + j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      mat_q  <= mat_d;
      vec2_q <= vec1_q;
    end
  end

  assign mat_o = mat_q;
  assign vec_o = vec2_q;

endmodule

// File: design/qvr_lane.sv
module qvr_lane import qvr_pkg::*; (
  input  logic     clk_i,
  input  qvr_adv_t adv_i,
  input  row_t     row_i,
  input  vec3_t    vec_i,
  output vec_t     res_o,
  output logic     sat_o
);

  // Stage 3: the three entry-by-component products of this row.
  lprod_t prod_q [3];

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= lprod_t'($signed(row_i[j])) * lprod_t'($signed(vec_i[j]));
      end
    end
  end

  // Stage 4: sum, round half up by 16 bits, clip to the component range.
  acc_t acc;
  acc_t rnd;
  vec_t res_d;
  logic sat_d;
  vec_t res_q;
  logic sat_q;

  always_comb begin
    acc = lprod_ext(prod_q[0]) + lprod_ext(prod_q[1]) + lprod_ext(prod_q[2]);
    rnd = (acc + RndOut) >>> 16;
    if (rnd > VecMax) begin
      res_d = VecMax[VecWidth-1:0];
      sat_d = 1'b1;
    end else if (rnd < VecMin) begin
      res_d = VecMin[VecWidth-1:0];
      sat_d = 1'b1;
    end else begin
      res_d = rnd[VecWidth-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

// File: test/quaternion_vector_rotator_core_tb.sv
`timescale 1ns / 100ps

// Stand-alone bench for the quaternion vector rotator pipeline.
// An initial block queues input beats (directed corner cases first, then
// random traffic), a clocked driver feeds them to the input channel, and a
// clocked monitor compares every output beat with the rotation that the bench
// itself works out for the matching input beat.
module quaternion_vector_rotator_core_tb;
  import qvr_pkg::*;

  // Rotation direction carried in the mode bit of an input beat.
  localparam logic ModeToBody     = 1'b0;
  localparam logic ModeToInertial = 1'b1;

  // Cycles without any accepted beat on either channel before giving up.
  localparam int StallLimit = 2000;
  // Cycles to keep watching the output once nothing is expected; the
  // pipeline is five stages deep, so this leaves a good margin.
  localparam int DrainCycles = 12;
  localparam int RandomBeats = 400;

  typedef struct {
    logic       mode;
    quat_comp_t w;
    quat_comp_t x;
    quat_comp_t y;
    quat_comp_t z;
    vec_t       vx;
    vec_t       vy;
    vec_t       vz;
  } rot_req_t;

  typedef struct {
    vec_t x;
    vec_t y;
    vec_t z;
    logic sat;
  } rot_res_t;

  logic clk;
  logic rst_n;

  qvr_in_if  in_ch ();
  qvr_out_if out_ch ();

  quaternion_vector_rotator_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rot_req_t pending_beats[$];
  rot_res_t expected_vecs[$];
  int       mismatches;
  int       taken_cnt;
  int       idle_cycles;
  logic     calm;

  // While calm is high neither side idles, so the pipeline runs at full rate
  // for a long stretch in the middle of the random traffic.
  assign calm = (taken_cnt >= 150) && (taken_cnt < 270);

  always #5 clk = ~clk;

  // Rotate one input beat the way the hardware should. Quaternion products
  // are exact in units of 2^-28, each matrix entry is rounded half up to 16
  // fractional bits, and each output sum is rounded half up to an integer and
  // then clipped to the port width.
  function automatic rot_res_t rotate_vector(rot_req_t r);
    longint q0, q1, q2, q3, sq0, one_q, vmax, vmin, acc, rnd;
    longint v[3];
    longint raw[3][3];
    longint m[3][3];
    longint outv[3];
    rot_res_t res;
    q0 = r.w;
    q1 = r.x;
    q2 = r.y;
    q3 = r.z;
    v[0] = r.vx;
    v[1] = r.vy;
    v[2] = r.vz;
    one_q = longint'(1) <<< 28;
    sq0 = q0 * q0;
    vmax = (longint'(1) <<< (VecWidth - 1)) - 1;
    vmin = -vmax - 1;
    raw[0][0] = 2 * (sq0 + q1 * q1) - one_q;
    raw[0][1] = 2 * (q1 * q2 - q0 * q3);
    raw[0][2] = 2 * (q1 * q3 + q0 * q2);
    raw[1][0] = 2 * (q1 * q2 + q0 * q3);
    raw[1][1] = 2 * (sq0 + q2 * q2) - one_q;
    raw[1][2] = 2 * (q2 * q3 - q0 * q1);
    raw[2][0] = 2 * (q1 * q3 - q0 * q2);
    raw[2][1] = 2 * (q2 * q3 + q0 * q1);
    raw[2][2] = 2 * (sq0 + q3 * q3) - one_q;
    // Body-to-inertial uses the transposed matrix.
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (r.mode == ModeToInertial) begin
          m[j][i] = (raw[i][j] + 2048) >>> 12;
        end else begin
          m[i][j] = (raw[i][j] + 2048) >>> 12;
        end
      end
    end
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        acc += m[i][j] * v[j];
      end
      rnd = (acc + 32768) >>> 16;
      if (rnd > vmax) begin
        rnd = vmax;
        res.sat = 1'b1;
      end
      if (rnd < vmin) begin
        rnd = vmin;
        res.sat = 1'b1;
      end
      outv[i] = rnd;
    end
    res.x = vec_t'(outv[0]);
    res.y = vec_t'(outv[1]);
    res.z = vec_t'(outv[2]);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic add_beat(input logic mode, input int w, input int x, input int y,
                          input int z, input int vx, input int vy, input int vz);
    rot_req_t r;
    r.mode = mode;
    r.w    = quat_comp_t'(w);
    r.x    = quat_comp_t'(x);
    r.y    = quat_comp_t'(y);
    r.z    = quat_comp_t'(z);
    r.vx   = vec_t'(vx);
    r.vy   = vec_t'(vy);
    r.vz   = vec_t'(vz);
    pending_beats.push_back(r);
  endtask

  // A random beat. Most quaternions are close to unit length so the output
  // stays mostly in range; the rest are arbitrary, either within +-1.0 or
  // any 16-bit pattern at all, which drives saturation hard.
  task automatic add_random_beat();
    real a, b, c, d, n;
    int  kind;
    rot_req_t r;
    kind   = $urandom_range(99);
    r.mode = $urandom_range(1) ? ModeToInertial : ModeToBody;
    if (kind < 60) begin
      a = $urandom_range(65535) / 32767.5 - 1.0;
      b = $urandom_range(65535) / 32767.5 - 1.0;
      c = $urandom_range(65535) / 32767.5 - 1.0;
      d = $urandom_range(65535) / 32767.5 - 1.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 0.01) begin
        a = 1.0;
        b = 0.0;
        c = 0.0;
        d = 0.0;
        n = 1.0;
      end
      r.w = quat_comp_t'($rtoi(16384.0 * a / n));
      r.x = quat_comp_t'($rtoi(16384.0 * b / n));
      r.y = quat_comp_t'($rtoi(16384.0 * c / n));
      r.z = quat_comp_t'($rtoi(16384.0 * d / n));
    end else if (kind < 85) begin
      r.w = quat_comp_t'(int'($urandom_range(32768)) - 16384);
      r.x = quat_comp_t'(int'($urandom_range(32768)) - 16384);
      r.y = quat_comp_t'(int'($urandom_range(32768)) - 16384);
      r.z = quat_comp_t'(int'($urandom_range(32768)) - 16384);
    end else begin
      r.w = quat_comp_t'($urandom);
      r.x = quat_comp_t'($urandom);
      r.y = quat_comp_t'($urandom);
      r.z = quat_comp_t'($urandom);
    end
    // Small vectors now and then exercise rounding near zero.
    if ($urandom_range(99) < 30) begin
      r.vx = vec_t'(int'($urandom_range(2000)) - 1000);
      r.vy = vec_t'(int'($urandom_range(2000)) - 1000);
      r.vz = vec_t'(int'($urandom_range(2000)) - 1000);
    end else begin
      r.vx = vec_t'($urandom);
      r.vy = vec_t'($urandom);
      r.vz = vec_t'($urandom);
    end
    pending_beats.push_back(r);
  endtask

  // Input driver. When the current beat has been taken (or none is up), it
  // either offers the next queued beat or idles at random. The
  // expected rotation is recorded at the edge where the beat is accepted.
  always @(posedge clk or negedge rst_n) begin
    rot_req_t cur;
    rot_req_t nxt;
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.mode     <= ModeToBody;
      in_ch.quat_w   <= '0;
      in_ch.quat_x   <= '0;
      in_ch.quat_y   <= '0;
      in_ch.quat_z   <= '0;
      in_ch.vec_in_x <= '0;
      in_ch.vec_in_y <= '0;
      in_ch.vec_in_z <= '0;
      taken_cnt      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur.mode = in_ch.mode;
        cur.w    = in_ch.quat_w;
        cur.x    = in_ch.quat_x;
        cur.y    = in_ch.quat_y;
        cur.z    = in_ch.quat_z;
        cur.vx   = in_ch.vec_in_x;
        cur.vy   = in_ch.vec_in_y;
        cur.vz   = in_ch.vec_in_z;
        expected_vecs.push_back(rotate_vector(cur));
        taken_cnt <= taken_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
          nxt = pending_beats.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.mode     <= nxt.mode;
          in_ch.quat_w   <= nxt.w;
          in_ch.quat_x   <= nxt.x;
          in_ch.quat_y   <= nxt.y;
          in_ch.quat_z   <= nxt.z;
          in_ch.vec_in_x <= nxt.vx;
          in_ch.vec_in_y <= nxt.vy;
          in_ch.vec_in_z <= nxt.vz;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output backpressure: ready drops in about a quarter of the cycles,
  // except during the calm stretch.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // Output monitor. Every accepted output beat is matched against the oldest
  // outstanding expectation, one field at a time.
  always @(posedge clk) begin
    rot_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_vecs.size() == 0) begin
        report_mismatch("unexpected output beat, vec_out_x", out_ch.vec_out_x, 0);
      end else begin
        want = expected_vecs.pop_front();
        if (out_ch.vec_out_x !== want.x) begin
          report_mismatch("vec_out_x", out_ch.vec_out_x, want.x);
        end
        if (out_ch.vec_out_y !== want.y) begin
          report_mismatch("vec_out_y", out_ch.vec_out_y, want.y);
        end
        if (out_ch.vec_out_z !== want.z) begin
          report_mismatch("vec_out_z", out_ch.vec_out_z, want.z);
        end
        if (out_ch.saturated !== want.sat) begin
          report_mismatch("saturated", out_ch.saturated, want.sat);
        end
      end
    end
  end

  // Watchdog: a handshake hung on both sides at once ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("FAIL quaternion_vector_rotator_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    in_ch.valid  = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats. Identity rotation, both signs of w, with the vector
    // small and at its extremes.
    add_beat(ModeToBody, 16384, 0, 0, 0, 1, 2, 3);
    add_beat(ModeToBody, 16384, 0, 0, 0, 32767, -32768, 32767);
    add_beat(ModeToInertial, -16384, 0, 0, 0, -32768, -32768, -32768);
    // A quarter turn about z (cos and sin of 45 degrees in Q2.14), both
    // directions, so the transpose shows up as the opposite turn, then one about x.
    add_beat(ModeToBody, 11585, 0, 0, 11585, 1000, 0, 0);
    add_beat(ModeToInertial, 11585, 0, 0, 11585, 1000, 0, 0);
    add_beat(ModeToInertial, 11585, -11585, 0, 0, 0, 12345, -12345);
    // Half turns about each axis: negating -32768 must clip.
    add_beat(ModeToBody, 0, 16384, 0, 0, -32768, 32767, -32768);
    add_beat(ModeToBody, 0, 0, 16384, 0, -32768, -32768, 32767);
    add_beat(ModeToInertial, 0, 0, 0, 16384, 32767, -32768, 1);
    add_beat(ModeToBody, 0, 0, 0, -16384, 32767, 32767, -32768);
    // A third of a turn about the diagonal, which permutes the components.
    add_beat(ModeToBody, 8192, 8192, 8192, 8192, 32767, -32768, 5);
    add_beat(ModeToInertial, 8192, 8192, 8192, 8192, 32767, -32768, 5);
    // Quaternions far from unit length are used as given; large vectors clip.
    add_beat(ModeToBody, 16384, 16384, 16384, 16384, 32767, 32767, 32767);
    add_beat(ModeToInertial, 16384, -16384, 16384, -16384, 32767, -32768, 32767);
    add_beat(ModeToInertial, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
    add_beat(ModeToBody, 32767, 32767, 32767, 32767, -32768, -32768, -32768);
    add_beat(ModeToBody, 32767, -32768, 32767, -32768, -1, 1, -1);
    // The zero quaternion gives minus the identity.
    add_beat(ModeToBody, 0, 0, 0, 0, -32768, 32767, 0);
    // Tiny rotations with odd vectors land on rounding boundaries.
    add_beat(ModeToBody, 16384, 1, 0, 0, 32767, -32767, 3);
    add_beat(ModeToInertial, 16383, 0, -1, 1, -3, 7, -32767);
    add_beat(ModeToBody, 16384, 0, 0, 0, 0, 0, 0);

    // Let the sender stop until every directed result is back, so the
    // pipeline drains completely once before the random traffic.
    do @(negedge clk); while (pending_beats.size() != 0 || in_ch.valid);
    while (expected_vecs.size() != 0) @(negedge clk);

    for (int n = 0; n < RandomBeats; n++) begin
      add_random_beat();
    end

    do @(negedge clk); while (pending_beats.size() != 0 || in_ch.valid);
    while (expected_vecs.size() != 0) @(negedge clk);
    // Watch a little longer for stray output beats.
    repeat (DrainCycles) @(negedge clk);

    if (mismatches == 0) begin
      $display("PASS quaternion_vector_rotator_core");
    end else begin
      $display("FAIL quaternion_vector_rotator_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/qvr_pkg.sv
design/qvr_if.sv
design/qvr_matrix.sv
design/qvr_lane.sv
design/quaternion_vector_rotator_core.sv
test/quaternion_vector_rotator_core_tb.sv
